[rtl/asb_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// asb_pkg
// Shared constants, register codes and blend arithmetic for the affine
// sprite blend core.
// ============================================================================
package asb_pkg;

    localparam int FB_WIDTH  = 640;
    localparam int FB_HEIGHT = 480;
    localparam int TEX_DEPTH = 4096;
    localparam int TEX_AW    = $clog2(TEX_DEPTH);
    localparam int FRAC_BITS = 12;

    localparam int COEF_W  = 18;
    localparam int OFS_W   = 24;
    localparam int TSIZE_W = 13;
    localparam int COORD_W = 12;
    localparam int PIX_W   = 32;
    localparam int FA_W    = 19;
    localparam int PROD_W  = COEF_W + COORD_W;
    localparam int SUM_W   = 32;
    localparam int UV_W    = SUM_W - FRAC_BITS;
    localparam int ACC_W   = 16;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 56;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    typedef enum logic [2:0] {
        REG_COEF_A,
        REG_COEF_B,
        REG_COEF_C,
        REG_COEF_D,
        REG_OFFSET_U,
        REG_OFFSET_V,
        REG_TEX_WIDTH,
        REG_TEX_HEIGHT
    } t_reg_idx;

    typedef enum logic {
        OP_DRAW = 1'b0,
        OP_LOAD = 1'b1
    } t_opcode;

    // s*a + d*(255-a) for one color byte; at most 255*255, fits 16 bits.
    function automatic logic [ACC_W-1:0] blend_sum(input logic [7:0] s,
                                                   input logic [7:0] d,
                                                   input logic [7:0] a);
        logic [ACC_W-1:0] inv_a;
        inv_a = ACC_W'(8'd255 - a);
        return ACC_W'(s) * ACC_W'(a) + ACC_W'(d) * inv_a;
    endfunction

    // Exact floor(n / 255) for n below 65280, where the quotient fits 8 bits: (n + (n >> 8) + 1) >> 8.
    function automatic logic [7:0] div255(input logic [ACC_W-1:0] n);
        logic [ACC_W:0] t;
        t = (ACC_W+1)'(n) + (ACC_W+1)'(n >> 8) + (ACC_W+1)'(1);
        return t[ACC_W-1:8];
    endfunction

endpackage

[rtl/asb_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// asb_ram
// Generic single-port RAM with registered read data. The read register
// only loads when the port is enabled for a read, so it holds under stall.
// ============================================================================
module asb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/affine_sprite_blend_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// affine_sprite_blend_core
// Affine texture mapping with nearest-texel sampling and src-over blending.
// ============================================================================
//
//  Channel   | Dir | Handshake          | Contents
//  ----------+-----+--------------------+-------------------------------------
//  s_axis    | in  | tvalid / tready    | draw word (x, y, dest) or texel load
//  m_axis    | out | tvalid / tready    | one word per draw: enable, address,
//            |     |                    | blended pixel; loads give none
//  apb       | in  | psel/penable/pready| eight setup registers, 4-byte stride
//
//  Pipeline: six register stages; a draw accepted on s_axis leaves on m_axis
//  from the sixth, and one word can be accepted every clock unless m_axis stalls.
//  Loads write the texture RAM in the stage where draws read it, so words
//  act on the texture in input order. Reset: synchronous, active low; it
//  clears the stage valid bits and loads the register defaults, not the RAM.
//  Stalls: a stage holds only while its successor is full and stalled.
//
// Stage plan:
//   1  four coefficient products, screen bounds, framebuffer address
//   2  sums with offsets and round-half-up to texel coordinates u, v
//   3  texture bounds, texel address v*width+u modulo the RAM depth
//   4  RAM access (load writes, draw reads)
//   5  per-channel s*a + d*(255-a)
//   6  divide by 255, pack the output word
// ============================================================================
module affine_sprite_blend_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [11:0] screen_x, [23:12] screen_y, [55:24] dest_pixel,
    // [67:56] texel_index, [99:68] texel_value, [103:100] zero
    input  logic [asb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] opcode
    input  logic                         s_axis_tuser,

    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [18:0] frame_address, [50:19] blended_pixel, [55:51] zero
    output logic [asb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] write_enable
    output logic                         m_axis_tuser,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [asb_pkg::APB_AW-1:0]   paddr,
    input  logic [asb_pkg::APB_DW-1:0]   pwdata,
    output logic [asb_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    import asb_pkg::*;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] r_coef_a, r_coef_b, r_coef_c, r_coef_d;
    logic signed [OFS_W-1:0]  r_offset_u, r_offset_v;
    logic [TSIZE_W-1:0]       r_tex_width, r_tex_height;
    t_reg_idx                 w_reg_idx;
    logic                     w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a     <= COEF_W'(4096);
            r_coef_b     <= '0;
            r_coef_c     <= '0;
            r_coef_d     <= COEF_W'(4096);
            r_offset_u   <= '0;
            r_offset_v   <= '0;
            r_tex_width  <= TSIZE_W'(64);
            r_tex_height <= TSIZE_W'(64);
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_COEF_A:     r_coef_a     <= pwdata[COEF_W-1:0];
                REG_COEF_B:     r_coef_b     <= pwdata[COEF_W-1:0];
                REG_COEF_C:     r_coef_c     <= pwdata[COEF_W-1:0];
                REG_COEF_D:     r_coef_d     <= pwdata[COEF_W-1:0];
                REG_OFFSET_U:   r_offset_u   <= pwdata[OFS_W-1:0];
                REG_OFFSET_V:   r_offset_v   <= pwdata[OFS_W-1:0];
                REG_TEX_WIDTH:  r_tex_width  <= pwdata[TSIZE_W-1:0];
                REG_TEX_HEIGHT: r_tex_height <= pwdata[TSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Reads return the stored bits, zero-extended.
    always_comb begin
        unique case (w_reg_idx)
            REG_COEF_A:     prdata = APB_DW'($unsigned(r_coef_a));
            REG_COEF_B:     prdata = APB_DW'($unsigned(r_coef_b));
            REG_COEF_C:     prdata = APB_DW'($unsigned(r_coef_c));
            REG_COEF_D:     prdata = APB_DW'($unsigned(r_coef_d));
            REG_OFFSET_U:   prdata = APB_DW'($unsigned(r_offset_u));
            REG_OFFSET_V:   prdata = APB_DW'($unsigned(r_offset_v));
            REG_TEX_WIDTH:  prdata = APB_DW'(r_tex_width);
            REG_TEX_HEIGHT: prdata = APB_DW'(r_tex_height);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input word unpacking
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] w_x, w_y;
    logic [PIX_W-1:0]          w_dest, w_tex_val;
    logic [COORD_W-1:0]        w_tex_idx;

    assign w_x       = s_axis_tdata[11:0];
    assign w_y       = s_axis_tdata[23:12];
    assign w_dest    = s_axis_tdata[55:24];
    assign w_tex_idx = s_axis_tdata[67:56];
    assign w_tex_val = s_axis_tdata[99:68];

    // ------------------------------------------------------------------
    // Stage registers and the ready chain. A stage loads whenever it is
    // empty or its own contents move on in the same cycle.
    // ------------------------------------------------------------------
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r6_valid;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6;
    t_opcode r3_op;

    assign w_rdy6 = !r6_valid || m_axis_tready;
    assign w_rdy5 = !r5_valid || w_rdy6;
    assign w_rdy4 = !r4_valid || w_rdy5;
    assign w_rdy3 = !r3_valid || w_rdy4;
    assign w_rdy2 = !r2_valid || w_rdy3;
    assign w_rdy1 = !r1_valid || w_rdy2;

    assign s_axis_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            if (w_rdy1) r1_valid <= s_axis_tvalid;
            if (w_rdy2) r2_valid <= r1_valid;
            if (w_rdy3) r3_valid <= r2_valid;
            // Loads end at the RAM stage; only draws continue.
            if (w_rdy4) r4_valid <= r3_valid && (r3_op == OP_DRAW);
            if (w_rdy5) r5_valid <= r4_valid;
            if (w_rdy6) r6_valid <= r5_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: products, screen bounds and framebuffer address
    // ------------------------------------------------------------------
    t_opcode                   r1_op;
    logic signed [PROD_W-1:0]  r1_ax, r1_by, r1_cx, r1_dy;
    logic                      r1_scr;
    logic [FA_W-1:0]           r1_fa;
    logic [PIX_W-1:0]          r1_dest, r1_tex_val;
    logic [COORD_W-1:0]        r1_tex_idx;
    logic signed [COORD_W:0]   w_x_ext, w_y_ext;
    logic                      n1_scr;
    logic [FA_W-1:0]           n1_fa;

    assign w_x_ext = (COORD_W+1)'(w_x);
    assign w_y_ext = (COORD_W+1)'(w_y);
    assign n1_scr  = !w_x[COORD_W-1] && !w_y[COORD_W-1] &&
                     (w_x_ext < $signed((COORD_W+1)'(FB_WIDTH))) &&
                     (w_y_ext < $signed((COORD_W+1)'(FB_HEIGHT)));
    // Only used when on screen, so both coordinates are non-negative.
    assign n1_fa   = FA_W'(FA_W'(w_y[COORD_W-2:0]) * FA_W'(FB_WIDTH)) +
                     FA_W'(w_x[COORD_W-2:0]);

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_op      <= t_opcode'(s_axis_tuser);
            r1_ax      <= r_coef_a * w_x;
            r1_by      <= r_coef_b * w_y;
            r1_cx      <= r_coef_c * w_x;
            r1_dy      <= r_coef_d * w_y;
            r1_scr     <= n1_scr;
            r1_fa      <= n1_fa;
            r1_dest    <= w_dest;
            r1_tex_idx <= w_tex_idx;
            r1_tex_val <= w_tex_val;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: u and v, rounded half up (floor after adding one half)
    // ------------------------------------------------------------------
    t_opcode                 r2_op;
    logic signed [UV_W-1:0]  r2_u, r2_v;
    logic                    r2_scr;
    logic [FA_W-1:0]         r2_fa;
    logic [PIX_W-1:0]        r2_dest, r2_tex_val;
    logic [COORD_W-1:0]      r2_tex_idx;
    logic signed [SUM_W-1:0] w_su, w_sv;

    assign w_su = SUM_W'(r1_ax) + SUM_W'(r1_by) + SUM_W'(r_offset_u) + ROUND_HALF;
    assign w_sv = SUM_W'(r1_cx) + SUM_W'(r1_dy) + SUM_W'(r_offset_v) + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_op      <= r1_op;
            r2_u       <= w_su[SUM_W-1:FRAC_BITS];
            r2_v       <= w_sv[SUM_W-1:FRAC_BITS];
            r2_scr     <= r1_scr;
            r2_fa      <= r1_fa;
            r2_dest    <= r1_dest;
            r2_tex_idx <= r1_tex_idx;
            r2_tex_val <= r1_tex_val;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: texture bounds and texel address. For a load the RAM
    // address is the texel index.
    // ------------------------------------------------------------------
    logic                 r3_hit;
    logic                 r3_wr_ok;
    logic [TEX_AW-1:0]    r3_addr;
    logic [FA_W-1:0]      r3_fa;
    logic [PIX_W-1:0]     r3_dest, r3_tex_val;
    logic                 n3_in_tex;
    logic [2*TEX_AW-1:0]  w_row_prod;
    logic [TEX_AW-1:0]    n3_draw_addr;

    assign n3_in_tex = !r2_u[UV_W-1] && !r2_v[UV_W-1] &&
                       (r2_u[UV_W-2:0] < (UV_W-1)'(r_tex_width)) &&
                       (r2_v[UV_W-2:0] < (UV_W-1)'(r_tex_height));
    // The address wraps modulo the RAM depth, so only the low bits matter.
    assign w_row_prod   = r2_v[TEX_AW-1:0] * r_tex_width[TEX_AW-1:0];
    assign n3_draw_addr = w_row_prod[TEX_AW-1:0] + r2_u[TEX_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_op      <= r2_op;
            r3_hit     <= n3_in_tex && r2_scr;
            r3_wr_ok   <= ((COORD_W+1)'(r2_tex_idx) < (COORD_W+1)'(TEX_DEPTH));
            r3_addr    <= (r2_op == OP_LOAD) ? TEX_AW'(r2_tex_idx) : n3_draw_addr;
            r3_fa      <= r2_fa;
            r3_dest    <= r2_dest;
            r3_tex_val <= r2_tex_val;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: texture RAM. The read data register is the stage's texel.
    // ------------------------------------------------------------------
    logic             r4_hit;
    logic [FA_W-1:0]  r4_fa;
    logic [PIX_W-1:0] r4_dest;
    logic [PIX_W-1:0] w_texel;
    logic             w_ram_en, w_ram_we;

    assign w_ram_en = w_rdy4 && r3_valid;
    assign w_ram_we = (r3_op == OP_LOAD) && r3_wr_ok;

    asb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (TEX_DEPTH)
    ) u_tex_ram (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (r3_addr),
        .i_wdata (r3_tex_val),
        .o_rdata (w_texel)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r4_hit  <= r3_hit;
            r4_fa   <= r3_fa;
            r4_dest <= r3_dest;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: weighted sums per color byte
    // ------------------------------------------------------------------
    logic             r5_hit;
    logic [FA_W-1:0]  r5_fa;
    logic [ACC_W-1:0] r5_sum_r, r5_sum_g, r5_sum_b;

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r5_hit   <= r4_hit;
            r5_fa    <= r4_fa;
            r5_sum_r <= blend_sum(w_texel[31:24], r4_dest[31:24], w_texel[7:0]);
            r5_sum_g <= blend_sum(w_texel[23:16], r4_dest[23:16], w_texel[7:0]);
            r5_sum_b <= blend_sum(w_texel[15:8],  r4_dest[15:8],  w_texel[7:0]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: divide by 255 and form the output word. A miss gives a
    // word with every field zero.
    // ------------------------------------------------------------------
    logic             r6_we;
    logic [FA_W-1:0]  r6_fa;
    logic [PIX_W-1:0] r6_pix;

    always_ff @(posedge i_clk) begin
        if (w_rdy6) begin
            r6_we  <= r5_hit;
            r6_fa  <= r5_hit ? r5_fa : '0;
            r6_pix <= r5_hit ? {div255(r5_sum_r), div255(r5_sum_g),
                                div255(r5_sum_b), 8'hFF} : '0;
        end
    end

    assign m_axis_tvalid = r6_valid;
    assign m_axis_tuser  = r6_we;
    assign m_axis_tdata  = {(M_TDATA_W - FA_W - PIX_W)'(0), r6_pix, r6_fa};

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for affine_sprite_blend_core: random traffic with
// in-order result checking.
// ============================================================================
// Texel loads and pixel draws go in on the slave stream. A scoreboard
// predicts every draw's output word from its own copy of the setup registers
// and the texture store, then compares each output word with the oldest
// prediction. The bench sends a load before any draw that would read a texel
// that has not been written yet.
// ============================================================================
module tb;
    import asb_pkg::*;

    localparam int          CYCLE_LIMIT  = 150000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          PHASE_WORDS  = 72;
    localparam logic [31:0] COEF_MASK    = (32'd1 << COEF_W) - 1;
    localparam logic [31:0] OFS_MASK     = (32'd1 << OFS_W) - 1;
    localparam logic [31:0] TSIZE_MASK   = (32'd1 << TSIZE_W) - 1;

    typedef struct {
        logic              we;
        logic [FA_W-1:0]   addr;
        logic [PIX_W-1:0]  pixel;
    } t_pixel_write;

    typedef enum {
        SETUP_RANDOM,
        SETUP_TINY,
        SETUP_ZERO_WIDTH,
        SETUP_ZERO_HEIGHT,
        SETUP_MIN,
        SETUP_MAX,
        SETUP_WRAP
    } t_setup_kind;

    // Holds the predicted output words of draws still in flight.
    class t_blend_scoreboard;
        localparam longint HALF = longint'(1) << (FRAC_BITS - 1);

        longint       coef_ux, coef_uy, coef_vx, coef_vy;
        longint       shift_u, shift_v, tex_w, tex_h;
        logic [31:0]  texels [TEX_DEPTH];
        t_pixel_write writes_due [$];
        int           mismatches;

        function new();
            coef_ux    = 4096;
            coef_uy    = 0;
            coef_vx    = 0;
            coef_vy    = 4096;
            shift_u    = 0;
            shift_v    = 0;
            tex_w      = 64;
            tex_h      = 64;
            mismatches = 0;
        endfunction

        function void set_register(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_COEF_A:     coef_ux = $signed(val[COEF_W-1:0]);
                REG_COEF_B:     coef_uy = $signed(val[COEF_W-1:0]);
                REG_COEF_C:     coef_vx = $signed(val[COEF_W-1:0]);
                REG_COEF_D:     coef_vy = $signed(val[COEF_W-1:0]);
                REG_OFFSET_U:   shift_u = $signed(val[OFS_W-1:0]);
                REG_OFFSET_V:   shift_v = $signed(val[OFS_W-1:0]);
                REG_TEX_WIDTH:  tex_w   = val[TSIZE_W-1:0];
                REG_TEX_HEIGHT: tex_h   = val[TSIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // True when the screen point lands on the screen and inside the
        // texture; addr is then the texel it samples.
        function bit texel_hit(int x, int y, output logic [TEX_AW-1:0] addr);
            longint u, v;
            bit     in_tex, on_screen;
            u = (coef_ux * x + coef_uy * y + shift_u + HALF) >>> FRAC_BITS;
            v = (coef_vx * x + coef_vy * y + shift_v + HALF) >>> FRAC_BITS;
            in_tex    = u >= 0 && u < tex_w && v >= 0 && v < tex_h;
            on_screen = x >= 0 && x < FB_WIDTH && y >= 0 && y < FB_HEIGHT;
            addr = '0;
            if (in_tex && on_screen)
                addr = TEX_AW'((v * tex_w + u) % TEX_DEPTH);
            return in_tex && on_screen;
        endfunction

        function logic [7:0] over(logic [7:0] s, logic [7:0] d, logic [7:0] a);
            int n;
            n = int'(s) * int'(a) + int'(d) * (255 - int'(a));
            return 8'(n / 255);
        endfunction

        function void note_word(t_opcode op, logic [S_TDATA_W-1:0] word);
            int               x, y;
            logic [31:0]      dest, src;
            logic [TEX_AW-1:0] addr;
            t_pixel_write     w;
            if (op == OP_LOAD) begin
                texels[word[67:56]] = word[99:68];
                return;
            end
            x    = $signed(word[11:0]);
            y    = $signed(word[23:12]);
            dest = word[55:24];
            w.we    = 1'b0;
            w.addr  = '0;
            w.pixel = '0;
            if (texel_hit(x, y, addr)) begin
                src     = texels[addr];
                w.we    = 1'b1;
                w.addr  = FA_W'(y * FB_WIDTH + x);
                w.pixel = {over(src[31:24], dest[31:24], src[7:0]),
                           over(src[23:16], dest[23:16], src[7:0]),
                           over(src[15:8],  dest[15:8],  src[7:0]), 8'hFF};
            end
            writes_due.push_back(w);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(logic we, logic [M_TDATA_W-1:0] word);
            t_pixel_write w;
            if (writes_due.size() == 0) begin
                report_mismatch($sformatf("output word %h with no draw pending", word));
                return;
            end
            w = writes_due.pop_front();
            if (we !== w.we)
                report_mismatch($sformatf("write_enable %b, expected %b", we, w.we));
            if (word[18:0] !== w.addr)
                report_mismatch($sformatf("frame_address %0d, expected %0d",
                                          word[18:0], w.addr));
            if (word[50:19] !== w.pixel)
                report_mismatch($sformatf("blended_pixel %h, expected %h",
                                          word[50:19], w.pixel));
        endtask

        function int pending();
            return writes_due.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    t_blend_scoreboard sb = new();
    bit              no_idle = 1'b0;
    bit              tex_loaded [TEX_DEPTH];
    int              words_sent = 0;
    int              cycle_count = 0;
    int              center_x, center_y;

    affine_sprite_blend_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver stalls at random unless the current phase runs flat out.
    always @(posedge i_clk)
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 36);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_word(t_opcode'(s_axis_tuser), s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** affine_sprite_blend_core: FAILED **");
            $finish;
        end
    end

    // Holds tvalid until the word is taken; tvalid stays high on return.
    task automatic send_word(t_opcode op, logic [11:0] x, logic [11:0] y,
                             logic [31:0] dest, logic [TEX_AW-1:0] idx,
                             logic [31:0] val);
        while (!no_idle && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, val, idx, dest, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_load(logic [TEX_AW-1:0] idx, logic [31:0] val);
        tex_loaded[idx] = 1'b1;
        send_word(OP_LOAD, 12'($urandom), 12'($urandom), $urandom, idx, val);
    endtask

    // A draw that would sample an unwritten texel gets that texel loaded first.
    task automatic send_draw(int x, int y, logic [31:0] dest);
        logic [TEX_AW-1:0] addr;
        if (sb.texel_hit(x, y, addr) && !tex_loaded[addr])
            send_load(addr, $urandom);
        send_word(OP_DRAW, 12'(x), 12'(y), dest, TEX_AW'($urandom), $urandom);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending and let every draw and any trailing load leave the pipe.
    // The first edge lets the monitor note the last word taken.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_setup(t_setup_kind kind);
        longint a, b, c, d, ou, ov, tw, th;
        a = $urandom_range(0, 12000) - 6000;
        b = $urandom_range(0, 12000) - 6000;
        c = $urandom_range(0, 12000) - 6000;
        d = $urandom_range(0, 12000) - 6000;
        tw = $urandom_range(1, 64);
        th = $urandom_range(1, 64);
        center_x = $urandom_range(40, 600);
        center_y = $urandom_range(40, 440);
        case (kind)
            SETUP_TINY: begin
                tw = 1;
                th = 1;
            end
            SETUP_ZERO_WIDTH:  tw = 0;
            SETUP_ZERO_HEIGHT: th = 0;
            SETUP_WRAP: begin
                a  = 4096;
                b  = 0;
                c  = 0;
                d  = 4096;
                tw = 4096;
                th = 4096;
            end
            default: ;
        endcase
        // Put the texture center under the chosen screen point.
        ou = tw * 2048 - (a * center_x + b * center_y);
        ov = th * 2048 - (c * center_x + d * center_y);
        if (kind == SETUP_WRAP) begin
            ou = 0;
            ov = 0;
        end
        if (kind == SETUP_MIN) begin
            a  = -131072;
            b  = -131072;
            c  = -131072;
            d  = -131072;
            ou = -8388608;
            ov = -8388608;
            tw = 8191;
            th = 8191;
        end
        if (kind == SETUP_MAX) begin
            // Steep slopes: only points near the origin stay in the texture.
            a  = 131071;
            b  = 131071;
            c  = 131071;
            d  = 131071;
            ou = 8388607;
            ov = 8388607;
            tw = 4096;
            th = 4096;
            center_x = 16;
            center_y = 16;
        end
        write_reg(REG_COEF_A,     32'(a) & COEF_MASK);
        write_reg(REG_COEF_B,     32'(b) & COEF_MASK);
        write_reg(REG_COEF_C,     32'(c) & COEF_MASK);
        write_reg(REG_COEF_D,     32'(d) & COEF_MASK);
        write_reg(REG_OFFSET_U,   32'(ou) & OFS_MASK);
        write_reg(REG_OFFSET_V,   32'(ov) & OFS_MASK);
        write_reg(REG_TEX_WIDTH,  32'(tw) & TSIZE_MASK);
        write_reg(REG_TEX_HEIGHT, 32'(th) & TSIZE_MASK);
    endtask

    // Mostly draws clustered around the mapped center, plus loads to random
    // addresses and draws anywhere in the coordinate range.
    task automatic run_traffic(int n_words);
        int stop_at, pick;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                send_load(TEX_AW'($urandom), $urandom);
            else if (pick < 30)
                send_draw($signed(12'($urandom)), $signed(12'($urandom)), $urandom);
            else
                send_draw(center_x + $urandom_range(0, 80) - 40,
                          center_y + $urandom_range(0, 80) - 40, $urandom);
        end
    endtask

    t_setup_kind phase_plan [9] = '{SETUP_RANDOM, SETUP_TINY, SETUP_ZERO_WIDTH,
                                    SETUP_MAX, SETUP_WRAP, SETUP_MIN,
                                    SETUP_ZERO_HEIGHT, SETUP_RANDOM, SETUP_RANDOM};

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setup is an identity map onto a 64x64 texture, so screen
        // (x, y) samples texel y*64+x here.
        send_load(TEX_AW'(0), 32'hFFFF_FFFF);          // opaque white
        send_load(TEX_AW'(TEX_DEPTH - 1), 32'h0000_0000); // fully transparent
        send_load(TEX_AW'(65), 32'h8040_2080);         // half alpha
        send_draw(0, 0, 32'h0000_0000);
        send_draw(63, 63, 32'hFFFF_FFFF);
        send_draw(1, 1, 32'h1234_5678);
        send_draw(1, 1, 32'hFFFF_FFFF);
        send_draw(64, 0, 32'hA5A5_A5A5);               // just right of texture
        send_draw(0, 64, 32'h5A5A_5A5A);               // just below texture
        send_draw(-1, 0, 32'h0000_0000);               // left of screen
        send_draw(0, -1, 32'h0000_0000);               // above screen
        send_draw(639, 479, 32'hFFFF_FFFF);            // last pixel, off texture
        send_draw(-2048, -2048, 32'h0000_0000);
        send_draw(2047, 2047, 32'hFFFF_FFFF);
        send_draw(2047, -2048, 32'h0F0F_0F0F);
        send_draw(-2048, 2047, 32'hF0F0_F0F0);
        send_draw(63, 0, 32'h8000_0001);
        send_draw(0, 63, 32'h0000_0080);
        settle();

        foreach (phase_plan[p]) begin
            no_idle = (phase_plan[p] == SETUP_WRAP);
            program_setup(phase_plan[p]);
            run_traffic(PHASE_WORDS);
            settle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** affine_sprite_blend_core: PASSED **");
        else
            $display("** affine_sprite_blend_core: FAILED **");
        $finish;
    end

endmodule
